/* hdl/delta_word_rle_planar_frame_decoder_defines.svh */
// Assertion macros used by the decoder's store engine (dwrle_back).
`ifndef DELTA_WORD_RLE_PLANAR_FRAME_DECODER_DEFINES_SVH
`define DELTA_WORD_RLE_PLANAR_FRAME_DECODER_DEFINES_SVH
`ifndef ASSERT_OFF
`define DWRLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define DWRLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DWRLE_ASSERT_IMP(lbl, ante, cons, msg)
`define DWRLE_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* hdl/dwrle_pkg.sv */
package dwrle_pkg;

  localparam int PLANES       = 4;
  localparam int LINE_WORDS   = 20;
  localparam int SCREEN_LINES = 200;

  localparam int PLANE_SPAN    = LINE_WORDS * 2;
  localparam int LINE_BYTES    = PLANES * PLANE_SPAN;
  localparam int SCREEN_PIXELS = LINE_WORDS * 16;
  localparam int STORE_BYTES   = SCREEN_LINES * LINE_BYTES;
  localparam int LINE_IDX      = LINE_WORDS * PLANES;
  localparam int SCREEN_WORDS  = SCREEN_LINES * LINE_IDX;

  localparam int AW     = $clog2(STORE_BYTES);
  localparam int IDX_W  = 14;
  localparam int WORD_W = 16;
  localparam int CNT_W  = 15;
  localparam int REM_W  = (LINE_IDX > 1) ? $clog2(LINE_IDX) : 1;
  localparam int COL_W  = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
  localparam int PLN_W  = (PLANES > 1) ? $clog2(PLANES) : 1;
  localparam int OFS_W  = $clog2(7 * PLANE_SPAN + 511 * LINE_BYTES + 127 + 3);

  // Exact reciprocals for indexes below 2**IDX_W.
  localparam int RECIP_SH   = 23;
  localparam int RECIP_LINE = (2 ** RECIP_SH + LINE_IDX - 1) / LINE_IDX;
  localparam int RECIP_PLN  = (2 ** RECIP_SH + PLANES - 1) / PLANES;
  localparam int PROD_W     = IDX_W + RECIP_SH + 1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_STREAM = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam int CTRL_LIT_BIT = 15;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_PLACE,
    CMD_READ
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [WORD_W-1:0]  word;
    logic [CNT_W-1:0]   count;
    logic [IDX_W-1:0]   idx;
    logic [8:0]         box_x;
    logic [7:0]         box_y;
    logic [8:0]         box_w;
    logic [7:0]         box_h;
    logic               xor_mode;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

/* hdl/dwrle_ram.sv */
module dwrle_ram #(
  parameter int W = 8,
  parameter int D = 32000
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* hdl/dwrle_front.sv */
module dwrle_front import dwrle_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [1:0]        opcode_i,
  input  logic [WORD_W-1:0] stream_word_i,
  input  logic [IDX_W-1:0]  read_index_i,
  input  logic [8:0]        box_x_i,
  input  logic [7:0]        box_y_i,
  input  logic [8:0]        box_width_i,
  input  logic [7:0]        box_height_i,
  input  logic              xor_mode_i,
  input  back_stat_t        stat_i,
  input  logic              q_full_i,
  output logic              push_o,
  output cmd_t              cmd_o
);

  localparam logic [1:0] PH_CTRL = 2'd0;
  localparam logic [1:0] PH_REP  = 2'd1;
  localparam logic [1:0] PH_LIT  = 2'd2;

  logic [1:0]       phase_q, phase_d;
  logic [CNT_W-1:0] run_q, run_d;
  logic             acc;

  assign ready_o = !q_full_i && !stat_i.clearing;
  assign acc     = valid_i && ready_o;

  always_comb begin
    phase_d       = phase_q;
    run_d         = run_q;
    push_o        = 1'b0;
    cmd_o.kind    = CMD_PLACE;
    cmd_o.word    = stream_word_i;
    cmd_o.count   = run_q;
    cmd_o.idx     = read_index_i;
    cmd_o.box_x   = box_x_i;
    cmd_o.box_y   = box_y_i;
    cmd_o.box_w   = box_width_i;
    cmd_o.box_h   = box_height_i;
    cmd_o.xor_mode = xor_mode_i;
    if (acc) begin
      unique case (opcode_i)
        OP_START: begin
          cmd_o.kind = CMD_START;
          push_o     = 1'b1;
          phase_d    = PH_CTRL;
          run_d      = '0;
        end
        OP_STREAM: begin
          unique case (phase_q)
            PH_REP: begin
              // A zero repeat count places nothing, so nothing is queued.
              push_o  = (run_q != '0);
              phase_d = PH_CTRL;
              run_d   = '0;
            end
            PH_LIT: begin
              cmd_o.count = CNT_W'(1);
              push_o      = 1'b1;
              run_d       = run_q - CNT_W'(1);
              if (run_d == '0) begin
                phase_d = PH_CTRL;
              end
            end
            default: begin
              run_d = stream_word_i[CNT_W-1:0];
              if (stream_word_i[CTRL_LIT_BIT]) begin
                phase_d = (run_d != '0) ? PH_LIT : PH_CTRL;
              end else begin
                phase_d = PH_REP;
              end
            end
          endcase
        end
        OP_READ: begin
          cmd_o.kind = CMD_READ;
          push_o     = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CTRL;
      run_q   <= '0;
    end else begin
      phase_q <= phase_d;
      run_q   <= run_d;
    end
  end

endmodule

/* hdl/dwrle_fifo.sv */
module dwrle_fifo import dwrle_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0] wp_q, rp_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rp_q <= rp_q + QPTR_W'(1);
      end
      cnt_q <= cnt_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(pop_i);
    end
  end

endmodule

/* hdl/dwrle_back.sv */
`include "delta_word_rle_planar_frame_decoder_defines.svh"
module dwrle_back import dwrle_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic              q_empty_i,
  output logic              pop_o,
  output back_stat_t        stat_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [WORD_W-1:0] out_word_o
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD0  = 4'd2;
  localparam logic [3:0] S_RD1  = 4'd3;
  localparam logic [3:0] S_RD2  = 4'd4;
  localparam logic [3:0] S_RD3  = 4'd5;
  localparam logic [3:0] S_OFS  = 4'd6;
  localparam logic [3:0] S_R0   = 4'd7;
  localparam logic [3:0] S_R1   = 4'd8;
  localparam logic [3:0] S_R2   = 4'd9;
  localparam logic [3:0] S_R3   = 4'd10;
  localparam logic [3:0] S_R4   = 4'd11;
  localparam logic [3:0] S_R5   = 4'd12;
  localparam logic [3:0] S_R6   = 4'd13;
  localparam logic [3:0] S_R7   = 4'd14;

  logic [3:0]        state_q, state_d;
  logic [AW-1:0]     clr_q;
  logic [8:0]        left_q;
  logic [7:0]        top_q;
  logic [9:0]        right_end_q;
  logic [8:0]        bottom_end_q;
  logic              xor_q;
  logic [9:0]        cx_q, cx_d;
  logic [8:0]        cy_q, cy_d;
  logic [2:0]        pl_q, pl_d;
  logic [OFS_W-1:0]  off_q;
  logic [WORD_W-1:0] word_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [IDX_W-1:0]  idx_q;
  logic              oor_q;
  logic [IDX_W-1:0]  line_q;
  logic [REM_W-1:0]  rem_q;
  logic [COL_W-1:0]  col_q;
  logic [PLN_W-1:0]  pln_q;
  logic [AW-1:0]     ra_q;
  logic [7:0]        hi_q;
  logic              out_v_q;
  logic [WORD_W-1:0] out_q;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [7:0]        wdata, rdata;
  logic [OFS_W-1:0]  baddr;
  logic              bvalid;
  logic [7:0]        bval, bkeep;
  logic [23:0]       shifted;
  logic [2:0]        b;
  logic [8:0]        cy_inc;
  logic [10:0]       nx;
  logic [PROD_W-1:0] prod_line, prod_col;
  logic              take;

  dwrle_ram #(.W(8), .D(STORE_BYTES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign b       = left_q[2:0];
  assign shifted = 24'(word_q) << (4'd8 - {1'b0, b});
  assign take    = !out_v_q || out_ready_i;

  assign prod_line = PROD_W'(idx_q) * PROD_W'(RECIP_LINE);
  assign prod_col  = PROD_W'(rem_q) * PROD_W'(RECIP_PLN);

  assign stat_o.clearing = (state_q == S_CLR);
  assign pop_o           = (state_q == S_IDLE) && !q_empty_i;
  assign out_valid_o     = out_v_q;
  assign out_word_o      = out_q;

  // Byte lane of the word being placed and the read address.
  always_comb begin
    baddr  = off_q;
    bvalid = 1'b0;
    bval   = shifted[23:16];
    bkeep  = 8'(16'hff00 >> b);
    raddr  = AW'(off_q);
    unique case (state_q)
      S_RD0: raddr = AW'(off_q);
      S_RD1: begin
        baddr  = off_q;
        bvalid = 1'b1;
        raddr  = AW'(off_q + OFS_W'(1));
      end
      S_RD2: begin
        baddr  = off_q + OFS_W'(1);
        bvalid = ({1'b0, cx_q} < 11'(SCREEN_PIXELS - 8));
        bval   = shifted[15:8];
        bkeep  = 8'h00;
        raddr  = AW'(off_q + OFS_W'(2));
      end
      S_RD3: begin
        baddr  = off_q + OFS_W'(2);
        bvalid = ({1'b0, cx_q} < 11'(SCREEN_PIXELS - 16));
        bval   = shifted[7:0];
        bkeep  = 8'hff >> b;
      end
      S_R5: raddr = ra_q;
      S_R6, S_R7: raddr = ra_q + AW'(1);
      default: begin
      end
    endcase
  end

  always_comb begin
    if (state_q == S_CLR) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = 8'h00;
    end else begin
      we    = bvalid && (baddr < OFS_W'(STORE_BYTES));
      waddr = AW'(baddr);
      wdata = xor_q ? (rdata ^ bval) : ((rdata & bkeep) | bval);
    end
  end

  // Cursor step: down the box, then a 16-pixel column right, then next plane.
  always_comb begin
    cy_inc = cy_q + 9'd1;
    cy_d   = cy_inc;
    cx_d   = cx_q;
    pl_d   = pl_q;
    nx     = 11'(cx_q) + 11'd16;
    if (cy_inc >= bottom_end_q) begin
      cy_d = 9'(top_q);
      if (nx >= {1'b0, right_end_q}) begin
        nx   = 11'(left_q);
        pl_d = pl_q + 3'd1;
      end
      cx_d = nx[9:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:  state_d = (clr_q == AW'(STORE_BYTES - 1)) ? S_IDLE : S_CLR;
      S_IDLE: begin
        if (!q_empty_i) begin
          unique case (cmd_i.kind)
            CMD_START: state_d = S_OFS;
            CMD_PLACE: state_d = S_RD0;
            CMD_READ:  state_d = S_R0;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_RD0: state_d = S_RD1;
      S_RD1: state_d = S_RD2;
      S_RD2: state_d = S_RD3;
      S_RD3: state_d = S_OFS;
      S_OFS: state_d = (cnt_q != '0) ? S_RD0 : S_IDLE;
      S_R0:  state_d = S_R1;
      S_R1:  state_d = S_R2;
      S_R2:  state_d = S_R3;
      S_R3:  state_d = S_R4;
      S_R4:  state_d = S_R5;
      S_R5:  state_d = S_R6;
      S_R6:  state_d = S_R7;
      S_R7:  state_d = take ? S_IDLE : S_R7;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      clr_q        <= '0;
      left_q       <= '0;
      top_q        <= '0;
      right_end_q  <= '0;
      bottom_end_q <= '0;
      xor_q        <= 1'b0;
      cx_q         <= '0;
      cy_q         <= '0;
      pl_q         <= '0;
      off_q        <= '0;
      cnt_q        <= '0;
      out_v_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (state_q == S_R7 && take) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            if (cmd_i.kind == CMD_START) begin
              left_q       <= cmd_i.box_x;
              top_q        <= cmd_i.box_y;
              right_end_q  <= 10'(cmd_i.box_x) + 10'(cmd_i.box_w);
              bottom_end_q <= 9'(cmd_i.box_y) + 9'(cmd_i.box_h);
              xor_q        <= cmd_i.xor_mode;
              cx_q         <= 10'(cmd_i.box_x);
              cy_q         <= 9'(cmd_i.box_y);
              pl_q         <= '0;
              cnt_q        <= '0;
            end else if (cmd_i.kind == CMD_PLACE) begin
              cnt_q <= cmd_i.count;
            end
          end
        end
        S_RD3: begin
          cx_q  <= cx_d;
          cy_q  <= cy_d;
          pl_q  <= pl_d;
          cnt_q <= cnt_q - CNT_W'(1);
        end
        S_OFS: begin
          off_q <= OFS_W'(pl_q) * OFS_W'(PLANE_SPAN) + OFS_W'(cy_q) * OFS_W'(LINE_BYTES)
                   + OFS_W'(cx_q[9:3]);
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers of the command in flight and the read pipeline.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      word_q <= cmd_i.word;
      idx_q  <= cmd_i.idx;
      oor_q  <= (cmd_i.idx >= IDX_W'(SCREEN_WORDS));
    end
    if (state_q == S_R0) begin
      line_q <= prod_line[RECIP_SH +: IDX_W];
    end
    if (state_q == S_R1) begin
      rem_q <= REM_W'(idx_q - IDX_W'(line_q * IDX_W'(LINE_IDX)));
    end
    if (state_q == S_R2) begin
      col_q <= prod_col[RECIP_SH +: COL_W];
    end
    if (state_q == S_R3) begin
      pln_q <= PLN_W'(rem_q - REM_W'(col_q * REM_W'(PLANES)));
    end
    if (state_q == S_R4) begin
      ra_q <= AW'(line_q * AW'(LINE_BYTES)) + AW'(pln_q * AW'(PLANE_SPAN))
              + AW'({col_q, 1'b0});
    end
    if (state_q == S_R6) begin
      hi_q <= rdata;
    end
    if (state_q == S_R7 && take) begin
      out_q <= oor_q ? '0 : {hi_q, rdata};
    end
  end

  `DWRLE_ASSERT_IMP(a_we_states, we, (state_q == S_CLR || state_q == S_RD1 || state_q == S_RD2 || state_q == S_RD3), "store written outside clear or place")
  `DWRLE_ASSERT_NXT(a_rmw_seq, state_q == S_RD1, state_q == S_RD2, "place sequence broken")
  `DWRLE_ASSERT_NXT(a_out_hold, state_q == S_R7 && out_v_q && !out_ready_i, state_q == S_R7 && out_v_q, "read result lost while stalled")
  `DWRLE_ASSERT_IMP(a_no_pop_clr, state_q == S_CLR, !pop_o && we && wdata == 8'h00, "clear pass disturbed")

endmodule

/* hdl/delta_word_rle_planar_frame_decoder.sv */
// Channel   | Dir | Group          | Contents
// ----------+-----+----------------+-------------------------------------------
// s_axis    | in  | tvalid/tready  | one request: start frame, stream word, read
// m_axis    | out | tvalid/tready  | one screen word per read request
//
// Each queued command costs one pop in the store engine. A placed word then steps through a
// first byte read, three read-modify-write byte steps and a next byte address step, per literal
// word or per repetition of a repeat run. A read holds the engine through a pop, an index split
// through two reciprocal multiplies and two store reads, plus any m_axis stall; start only sets
// the byte address and control words queue nothing. After reset a clearing pass zeroes the store
// with s_axis_tready low; a full four-entry command queue also drops s_axis_tready.
module delta_word_rle_planar_frame_decoder import dwrle_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Bits from 0 up: stream_word[15:0], read_index[29:16], box_x[38:30],
  // box_y[46:39], box_width[55:47], box_height[63:56], xor_mode[64], zero pad.
  input  logic [71:0] s_axis_tdata,
  // Bits from 0 up: opcode[1:0].
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Bits from 0 up: screen_word[15:0].
  output logic [15:0] m_axis_tdata
);

  back_stat_t stat;
  cmd_t       push_cmd, head_cmd;
  logic       push, pop, q_full, q_empty;

  // The front parses the request stream and queues store commands.
  dwrle_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s_axis_tvalid),
    .ready_o       (s_axis_tready),
    .opcode_i      (s_axis_tuser),
    .stream_word_i (s_axis_tdata[15:0]),
    .read_index_i  (s_axis_tdata[29:16]),
    .box_x_i       (s_axis_tdata[38:30]),
    .box_y_i       (s_axis_tdata[46:39]),
    .box_width_i   (s_axis_tdata[55:47]),
    .box_height_i  (s_axis_tdata[63:56]),
    .xor_mode_i    (s_axis_tdata[64]),
    .stat_i        (stat),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  dwrle_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .head_o  (head_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // The back owns the cursor, the frame store and the result register.
  dwrle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_word_o  (m_axis_tdata)
  );

endmodule
